// File: sv/nopr_pkg.sv
// nopr_pkg: shared types, widths and the constant origin frame table
// for the nearest origin pose rebase block. No dependencies.
`default_nettype none

package nopr_pkg;

    // operand and accumulator widths of the shared multiply-accumulate unit
    localparam int OPD_W = 33;
    localparam int ACC_W = 67;

    typedef logic signed [OPD_W-1:0] opd_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } mac_op_t;

    // frame words: 0..2 position, 3..6 quaternion w, x, y, z
    function automatic logic signed [31:0] frame_word(logic [3:0] row, logic [2:0] word);
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [31:0] qw;
        logic signed [31:0] qz;
        unique case (row)
            4'd0:    begin px = -32'sd5;       py = -32'sd1;       pz = 32'sd21311;
                           qw = 32'sd16384;    qz = 32'sd0;      end
            4'd1:    begin px = 32'sd9406272;  py = 32'sd18786508; pz = -32'sd529049;
                           qw = 32'sd16374;    qz = -32'sd561;   end
            4'd2:    begin px = 32'sd35896254; py = 32'sd33988227; pz = -32'sd1991487;
                           qw = 32'sd15840;    qz = -32'sd4188;  end
            4'd3:    begin px = 32'sd88460166; py = -32'sd6774929; pz = -32'sd487495;
                           qw = -32'sd393;     qz = 32'sd16379;  end
            4'd4:    begin px = 32'sd77075074; py = -32'sd27793853; pz = -32'sd5076254;
                           qw = 32'sd507;      qz = 32'sd16376;  end
            4'd5:    begin px = 32'sd51341350; py = -32'sd44262836; pz = -32'sd191431;
                           qw = 32'sd4599;     qz = 32'sd15725;  end
            4'd6:    begin px = 32'sd132023;   py = -32'sd18843189; pz = -32'sd239899;
                           qw = 32'sd16193;    qz = 32'sd2496;   end
            4'd7:    begin px = 32'sd46750157; py = -32'sd47719281; pz = -32'sd974130;
                           qw = 32'sd12618;    qz = 32'sd10450;  end
            4'd8:    begin px = 32'sd67673810; py = -32'sd31716639; pz = -32'sd3764132;
                           qw = 32'sd10633;    qz = 32'sd12465;  end
            4'd9:    begin px = 32'sd87014045; py = 32'sd10082070; pz = -32'sd2314033;
                           qw = -32'sd2570;    qz = 32'sd16181;  end
            4'd10:   begin px = 32'sd44351972; py = 32'sd35329138; pz = -32'sd3125533;
                           qw = -32'sd5687;    qz = 32'sd15365;  end
            4'd11:   begin px = 32'sd17332390; py = 32'sd26039385; pz = 32'sd1718;
                           qw = 32'sd12826;    qz = -32'sd10195; end
            default: begin px = 32'sd0;        py = 32'sd0;        pz = 32'sd0;
                           qw = 32'sd16384;    qz = 32'sd0;      end
        endcase
        unique case (word)
            3'd0:    return px;
            3'd1:    return py;
            3'd2:    return pz;
            3'd3:    return qw;
            3'd6:    return qz;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: sv/nearest_origin_pose_rebase.sv
// nearest_origin_pose_rebase: picks the nearest origin frame and rebases poses
// into it. Depends on nopr_pkg and nopr_mac.
//
// Input channel: in_valid/in_stall carries one word, command plus a pose.
// A pick word (command 0) searches the frame table for the nearest frame by
// squared distance and sets origin_valid when it lies within capture_radius.
// A transform word (command 1) rotates the pose into the selected origin.
// Output channel: out_valid/out_stall carries one result word per input word.
// Config: APB port, capture_radius at address 0; pready is always high.
// A pick runs one product per cycle through the shared multiply-accumulate
// unit, three axes per frame, then the radius square and decision. A
// transform with an origin runs 37 micro-steps through the same unit; a
// pass-through skips the unit.
// One word is in work at a time; in_stall is high from accept until the
// result is handed to the output register. A finished result waits there
// while out_stall is high; the next word can be taken meanwhile.
// Reset clears the origin mark, selects frame 0 and sets the radius to 5 m.
`default_nettype none

module nearest_origin_pose_rebase #(
    parameter int NUM_FRAMES = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input words
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               command,
    input  wire logic signed [31:0] in_pos_x,
    input  wire logic signed [31:0] in_pos_y,
    input  wire logic signed [31:0] in_pos_z,
    input  wire logic signed [15:0] in_quat_w,
    input  wire logic signed [15:0] in_quat_x,
    input  wire logic signed [15:0] in_quat_y,
    input  wire logic signed [15:0] in_quat_z,
    // result words
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_pos_x,
    output logic signed [31:0]      out_pos_y,
    output logic signed [31:0]      out_pos_z,
    output logic signed [15:0]      out_quat_w,
    output logic signed [15:0]      out_quat_x,
    output logic signed [15:0]      out_quat_y,
    output logic signed [15:0]      out_quat_z,
    output logic                    origin_valid,
    output logic [3:0]              origin_frame,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import nopr_pkg::*;

    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam logic [5:0] ROT_LAST = 6'd36;
    localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;
    localparam logic [30:0] RADIUS_RESET = 31'd327680;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_PFIN,
        S_PDEC,
        S_ROT,
        S_FIN
    } state_t;

    typedef enum logic [4:0] {
        OS_ZERO, OS_W, OS_A, OS_B, OS_C,
        OS_M0, OS_M1, OS_M2, OS_M3, OS_M4, OS_M5, OS_M6, OS_M7, OS_M8,
        OS_REL0, OS_REL1, OS_REL2,
        OS_Q0, OS_Q1, OS_Q2, OS_Q3,
        OS_D, OS_RAD
    } opd_sel_t;

    typedef enum logic [4:0] {
        D_NONE,
        D_PR0, D_PR1, D_PR2, D_PR3, D_PR4, D_PR5, D_PR6, D_PR7, D_PR8,
        D_MAT,
        D_BP0, D_BP1, D_BP2,
        D_BQ0, D_BQ1, D_BQ2, D_BQ3
    } dst_t;

    typedef struct packed {
        opd_sel_t a;
        opd_sel_t b;
        mac_op_t  op;
        dst_t     dst;
    } uop_t;

    // rotation and quaternion product program
    function automatic uop_t rot_uop(logic [5:0] step);
        unique case (step)
            6'd0:    return '{OS_B,  OS_B,    MAC_LOAD, D_NONE};
            6'd1:    return '{OS_C,  OS_C,    MAC_LOAD, D_PR0};
            6'd2:    return '{OS_A,  OS_A,    MAC_LOAD, D_PR1};
            6'd3:    return '{OS_A,  OS_B,    MAC_LOAD, D_PR2};
            6'd4:    return '{OS_W,  OS_C,    MAC_LOAD, D_PR3};
            6'd5:    return '{OS_A,  OS_C,    MAC_LOAD, D_PR4};
            6'd6:    return '{OS_W,  OS_B,    MAC_LOAD, D_PR5};
            6'd7:    return '{OS_B,  OS_C,    MAC_LOAD, D_PR6};
            6'd8:    return '{OS_W,  OS_A,    MAC_LOAD, D_PR7};
            6'd9:    return '{OS_ZERO, OS_ZERO, MAC_NOP, D_PR8};
            6'd10:   return '{OS_ZERO, OS_ZERO, MAC_NOP, D_MAT};
            6'd11:   return '{OS_M0, OS_REL0, MAC_LOAD, D_NONE};
            6'd12:   return '{OS_M1, OS_REL1, MAC_ADD,  D_NONE};
            6'd13:   return '{OS_M2, OS_REL2, MAC_ADD,  D_NONE};
            6'd14:   return '{OS_M3, OS_REL0, MAC_LOAD, D_BP0};
            6'd15:   return '{OS_M4, OS_REL1, MAC_ADD,  D_NONE};
            6'd16:   return '{OS_M5, OS_REL2, MAC_ADD,  D_NONE};
            6'd17:   return '{OS_M6, OS_REL0, MAC_LOAD, D_BP1};
            6'd18:   return '{OS_M7, OS_REL1, MAC_ADD,  D_NONE};
            6'd19:   return '{OS_M8, OS_REL2, MAC_ADD,  D_NONE};
            6'd20:   return '{OS_W,  OS_Q0,   MAC_LOAD, D_BP2};
            6'd21:   return '{OS_A,  OS_Q1,   MAC_SUB,  D_NONE};
            6'd22:   return '{OS_B,  OS_Q2,   MAC_SUB,  D_NONE};
            6'd23:   return '{OS_C,  OS_Q3,   MAC_SUB,  D_NONE};
            6'd24:   return '{OS_W,  OS_Q1,   MAC_LOAD, D_BQ0};
            6'd25:   return '{OS_A,  OS_Q0,   MAC_ADD,  D_NONE};
            6'd26:   return '{OS_B,  OS_Q3,   MAC_ADD,  D_NONE};
            6'd27:   return '{OS_C,  OS_Q2,   MAC_SUB,  D_NONE};
            6'd28:   return '{OS_W,  OS_Q2,   MAC_LOAD, D_BQ1};
            6'd29:   return '{OS_A,  OS_Q3,   MAC_SUB,  D_NONE};
            6'd30:   return '{OS_B,  OS_Q0,   MAC_ADD,  D_NONE};
            6'd31:   return '{OS_C,  OS_Q1,   MAC_ADD,  D_NONE};
            6'd32:   return '{OS_W,  OS_Q3,   MAC_LOAD, D_BQ2};
            6'd33:   return '{OS_A,  OS_Q2,   MAC_ADD,  D_NONE};
            6'd34:   return '{OS_B,  OS_Q1,   MAC_SUB,  D_NONE};
            6'd35:   return '{OS_C,  OS_Q0,   MAC_ADD,  D_NONE};
            6'd36:   return '{OS_ZERO, OS_ZERO, MAC_NOP, D_BQ3};
            default: return '{OS_ZERO, OS_ZERO, MAC_NOP, D_NONE};
        endcase
    endfunction

    // round to nearest, ties away from zero, then saturate
    function automatic logic signed [31:0] rnd28(acc_t v);
        logic [ACC_W-1:0] mag;
        logic             neg;
        neg = v[ACC_W-1];
        mag = neg ? $unsigned(-v) : $unsigned(v);
        mag = (mag + (ACC_W'(1) << 27)) >> 28;
        if (!neg && mag > ACC_W'(32'h7fff_ffff))
            return 32'sh7fff_ffff;
        else if (neg && mag > ACC_W'(33'h1_0000_0000 >> 1))
            return 32'sh8000_0000;
        else
            return neg ? -$signed(mag[31:0]) : $signed(mag[31:0]);
    endfunction

    function automatic logic signed [15:0] rnd14(acc_t v);
        logic [ACC_W-1:0] mag;
        logic             neg;
        neg = v[ACC_W-1];
        mag = neg ? $unsigned(-v) : $unsigned(v);
        mag = (mag + (ACC_W'(1) << 13)) >> 14;
        if (!neg && mag > ACC_W'(16'h7fff))
            return 16'sh7fff;
        else if (neg && mag > ACC_W'(17'h8000))
            return 16'sh8000;
        else
            return neg ? -$signed(mag[15:0]) : $signed(mag[15:0]);
    endfunction

    state_t                  state_reg;
    logic [CNT_W-1:0]        frame_cnt_reg;
    logic [1:0]              axis_reg;
    logic [5:0]              step_reg;
    logic [ACC_W-1:0]        best_reg;
    logic [3:0]              best_idx_reg;
    logic                    have_reg;
    logic [3:0]              chosen_reg;
    logic [30:0]             radius_reg;
    logic                    out_valid_reg;

    logic signed [31:0]      pos_reg [3];
    logic signed [15:0]      q_reg [4];
    opd_t                    rel_reg [3];
    logic signed [31:0]      pr_reg [9];
    logic signed [31:0]      mat_reg [9];
    logic signed [31:0]      bp_reg [3];
    logic signed [15:0]      bq_reg [4];

    logic signed [31:0]      out_pos_reg [3];
    logic signed [15:0]      out_q_reg [4];
    logic                    out_have_reg;
    logic [3:0]              out_frame_reg;

    logic                    accept;
    logic                    out_take;
    logic                    load_out;
    logic                    cfg_wr;
    uop_t                    uop;
    opd_t                    opd_a;
    opd_t                    opd_b;
    acc_t                    acc;
    logic                    cmp;
    logic                    cmp_first;
    logic [3:0]              cmp_idx;
    logic                    take_best;
    opd_t                    diff;
    opd_t                    cw;
    opd_t                    ca;
    opd_t                    cb;
    opd_t                    cc;
    logic [3:0]              pick_row;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign load_out = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign in_stall = (state_reg != S_IDLE);

    // conjugate of the origin quaternion and the current pick difference
    always_comb
    begin
        cw = OPD_W'(frame_word(chosen_reg, 3'd3));
        ca = -OPD_W'(frame_word(chosen_reg, 3'd4));
        cb = -OPD_W'(frame_word(chosen_reg, 3'd5));
        cc = -OPD_W'(frame_word(chosen_reg, 3'd6));
        pick_row = 4'(frame_cnt_reg);
        diff = OPD_W'(pos_reg[axis_reg]) - OPD_W'(frame_word(pick_row, {1'b0, axis_reg}));
    end

    // micro-step select for the shared unit
    always_comb
    begin
        uop = '{OS_ZERO, OS_ZERO, MAC_NOP, D_NONE};
        cmp = 1'b0;
        unique case (state_reg)
            S_PICK:
            begin
                uop = '{OS_D, OS_D, (axis_reg == 2'd0) ? MAC_LOAD : MAC_ADD, D_NONE};
                cmp = (axis_reg == 2'd0) && (frame_cnt_reg != '0);
            end
            S_PFIN:
            begin
                uop = '{OS_RAD, OS_RAD, MAC_LOAD, D_NONE};
                cmp = 1'b1;
            end
            S_ROT:
            begin
                uop = rot_uop(step_reg);
            end
            default:
            begin
                uop = '{OS_ZERO, OS_ZERO, MAC_NOP, D_NONE};
            end
        endcase
        cmp_idx   = 4'(frame_cnt_reg - 1'b1);
        cmp_first = (frame_cnt_reg == CNT_W'(1));
        take_best = cmp && (cmp_first || ($unsigned(acc) < best_reg));
    end

    // operand multiplexers
    function automatic opd_t pick_opd(opd_sel_t s, opd_t d, opd_t w, opd_t a, opd_t b,
                                      opd_t c, logic [30:0] rad);
        unique case (s)
            OS_W:    return w;
            OS_A:    return a;
            OS_B:    return b;
            OS_C:    return c;
            OS_M0:   return OPD_W'(mat_reg[0]);
            OS_M1:   return OPD_W'(mat_reg[1]);
            OS_M2:   return OPD_W'(mat_reg[2]);
            OS_M3:   return OPD_W'(mat_reg[3]);
            OS_M4:   return OPD_W'(mat_reg[4]);
            OS_M5:   return OPD_W'(mat_reg[5]);
            OS_M6:   return OPD_W'(mat_reg[6]);
            OS_M7:   return OPD_W'(mat_reg[7]);
            OS_M8:   return OPD_W'(mat_reg[8]);
            OS_REL0: return rel_reg[0];
            OS_REL1: return rel_reg[1];
            OS_REL2: return rel_reg[2];
            OS_Q0:   return OPD_W'(q_reg[0]);
            OS_Q1:   return OPD_W'(q_reg[1]);
            OS_Q2:   return OPD_W'(q_reg[2]);
            OS_Q3:   return OPD_W'(q_reg[3]);
            OS_D:    return d;
            OS_RAD:  return $signed({2'b00, rad});
            default: return '0;
        endcase
    endfunction

    // operand select, re-evaluated on any register the selectors read
    always_comb
    begin
        opd_a = pick_opd(uop.a, diff, cw, ca, cb, cc, radius_reg);
        opd_b = pick_opd(uop.b, diff, cw, ca, cb, cc, radius_reg);
    end

    nopr_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .opd_a (opd_a),
        .opd_b (opd_b),
        .op    (uop.op),
        .acc   (acc)
    );

    // sequencer state, origin selection, config and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            frame_cnt_reg <= '0;
            axis_reg      <= 2'd0;
            step_reg      <= 6'd0;
            have_reg      <= 1'b0;
            chosen_reg    <= 4'd0;
            radius_reg    <= RADIUS_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && !paddr[2])
                radius_reg <= pwdata[30:0];
            if (out_take)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        frame_cnt_reg <= '0;
                        axis_reg      <= 2'd0;
                        step_reg      <= 6'd0;
                        if (!command)
                            state_reg <= S_PICK;
                        else if (have_reg)
                            state_reg <= S_ROT;
                        else
                            state_reg <= S_FIN;
                    end
                end
                S_PICK:
                begin
                    if (axis_reg == 2'd2)
                    begin
                        axis_reg      <= 2'd0;
                        frame_cnt_reg <= frame_cnt_reg + 1'b1;
                        if (frame_cnt_reg == CNT_W'(NUM_FRAMES - 1))
                            state_reg <= S_PFIN;
                    end
                    else
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_PFIN:
                begin
                    state_reg <= S_PDEC;
                end
                S_PDEC:
                begin
                    // accumulator now holds the radius squared
                    chosen_reg <= best_idx_reg;
                    have_reg   <= (best_reg <= $unsigned(acc));
                    state_reg  <= S_FIN;
                end
                S_ROT:
                begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == ROT_LAST)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pos_reg[0] <= in_pos_x;
            pos_reg[1] <= in_pos_y;
            pos_reg[2] <= in_pos_z;
            q_reg[0]   <= in_quat_w;
            q_reg[1]   <= in_quat_x;
            q_reg[2]   <= in_quat_y;
            q_reg[3]   <= in_quat_z;
            rel_reg[0] <= OPD_W'(in_pos_x) - OPD_W'(frame_word(chosen_reg, 3'd0));
            rel_reg[1] <= OPD_W'(in_pos_y) - OPD_W'(frame_word(chosen_reg, 3'd1));
            rel_reg[2] <= OPD_W'(in_pos_z) - OPD_W'(frame_word(chosen_reg, 3'd2));
            if (command && !have_reg)
            begin
                bp_reg[0] <= in_pos_x;
                bp_reg[1] <= in_pos_y;
                bp_reg[2] <= in_pos_z;
                bq_reg[0] <= in_quat_w;
                bq_reg[1] <= in_quat_x;
                bq_reg[2] <= in_quat_y;
                bq_reg[3] <= in_quat_z;
            end
            else if (!command)
            begin
                for (int i = 0; i < 3; i++)
                    bp_reg[i] <= '0;
                for (int i = 0; i < 4; i++)
                    bq_reg[i] <= '0;
            end
        end

        // running minimum of the squared distance
        if (take_best)
        begin
            best_reg     <= $unsigned(acc);
            best_idx_reg <= cmp_idx;
        end

        // micro-step write-back
        if (state_reg == S_ROT)
        begin
            unique case (uop.dst)
                D_PR0: pr_reg[0] <= acc[31:0];
                D_PR1: pr_reg[1] <= acc[31:0];
                D_PR2: pr_reg[2] <= acc[31:0];
                D_PR3: pr_reg[3] <= acc[31:0];
                D_PR4: pr_reg[4] <= acc[31:0];
                D_PR5: pr_reg[5] <= acc[31:0];
                D_PR6: pr_reg[6] <= acc[31:0];
                D_PR7: pr_reg[7] <= acc[31:0];
                D_PR8: pr_reg[8] <= acc[31:0];
                D_MAT:
                begin
                    // products: bb, cc, aa, ab, wc, ac, wb, bc, wa
                    mat_reg[0] <= ONE_Q28 - ((pr_reg[0] + pr_reg[1]) <<< 1);
                    mat_reg[1] <= (pr_reg[3] - pr_reg[4]) <<< 1;
                    mat_reg[2] <= (pr_reg[5] + pr_reg[6]) <<< 1;
                    mat_reg[3] <= (pr_reg[3] + pr_reg[4]) <<< 1;
                    mat_reg[4] <= ONE_Q28 - ((pr_reg[2] + pr_reg[1]) <<< 1);
                    mat_reg[5] <= (pr_reg[7] - pr_reg[8]) <<< 1;
                    mat_reg[6] <= (pr_reg[5] - pr_reg[6]) <<< 1;
                    mat_reg[7] <= (pr_reg[7] + pr_reg[8]) <<< 1;
                    mat_reg[8] <= ONE_Q28 - ((pr_reg[2] + pr_reg[0]) <<< 1);
                end
                D_BP0: bp_reg[0] <= rnd28(acc);
                D_BP1: bp_reg[1] <= rnd28(acc);
                D_BP2: bp_reg[2] <= rnd28(acc);
                D_BQ0: bq_reg[0] <= rnd14(acc);
                D_BQ1: bq_reg[1] <= rnd14(acc);
                D_BQ2: bq_reg[2] <= rnd14(acc);
                D_BQ3: bq_reg[3] <= rnd14(acc);
                default:
                begin
                end
            endcase
        end

        // output word register
        if (load_out)
        begin
            for (int i = 0; i < 3; i++)
                out_pos_reg[i] <= bp_reg[i];
            for (int i = 0; i < 4; i++)
                out_q_reg[i] <= bq_reg[i];
            out_have_reg  <= have_reg;
            out_frame_reg <= chosen_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pos_x    = out_pos_reg[0];
    assign out_pos_y    = out_pos_reg[1];
    assign out_pos_z    = out_pos_reg[2];
    assign out_quat_w   = out_q_reg[0];
    assign out_quat_x   = out_q_reg[1];
    assign out_quat_y   = out_q_reg[2];
    assign out_quat_z   = out_q_reg[3];
    assign origin_valid = out_have_reg;
    assign origin_frame = out_frame_reg;

    // register read back
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, radius_reg};

endmodule

`default_nettype wire

// File: sv/nopr_mac.sv
// nopr_mac: shared signed multiply-accumulate unit, one product per cycle.
// Depends on nopr_pkg.
`default_nettype none

module nopr_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire nopr_pkg::opd_t  opd_a,
    input  wire nopr_pkg::opd_t  opd_b,
    input  wire nopr_pkg::mac_op_t op,
    output nopr_pkg::acc_t       acc
);
    import nopr_pkg::*;

    logic signed [2*OPD_W-1:0] prod;
    acc_t                      prod_ext;
    acc_t                      acc_reg;
    acc_t                      acc_next;

    // multiplier and accumulate select
    always_comb
    begin
        prod     = opd_a * opd_b;
        prod_ext = ACC_W'(prod);
        unique case (op)
            MAC_LOAD: acc_next = prod_ext;
            MAC_ADD:  acc_next = acc_reg + prod_ext;
            MAC_SUB:  acc_next = acc_reg - prod_ext;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// File: test/nearest_origin_pose_rebase_tb.sv
// nearest_origin_pose_rebase_tb: self-checking bench for the origin pick and
// pose rebase block. Depends on nearest_origin_pose_rebase and nopr_pkg.
`default_nettype none

module nearest_origin_pose_rebase_tb;

    localparam int NFRAMES = 12;
    localparam logic CMD_PICK = 1'b0;
    localparam logic CMD_XFORM = 1'b1;
    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam longint ONE_Q28 = 64'sd1 << 28;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
    } pose_word_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic               ovalid;
        logic [3:0]         oframe;
    } body_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    pose_word_t drv;
    logic out_valid;
    logic out_stall;
    body_word_t got;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    nearest_origin_pose_rebase dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(drv.cmd), .in_pos_x(drv.px), .in_pos_y(drv.py), .in_pos_z(drv.pz),
        .in_quat_w(drv.qw), .in_quat_x(drv.qx), .in_quat_y(drv.qy), .in_quat_z(drv.qz),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_pos_x(got.px), .out_pos_y(got.py), .out_pos_z(got.pz),
        .out_quat_w(got.qw), .out_quat_x(got.qx), .out_quat_y(got.qy),
        .out_quat_z(got.qz), .origin_valid(got.ovalid), .origin_frame(got.oframe),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // predictor state
    logic        pr_have;
    logic [3:0]  pr_frame;
    logic [30:0] pr_radius;

    pose_word_t  pose_q[$];
    body_word_t  body_q[$];
    int          errors = 0;
    bit          idle_rand = 1;

    function automatic longint frame_val(int row, int w);
        return longint'(nopr_pkg::frame_word(row[3:0], w[2:0]));
    endfunction

    function automatic longint rnd_shift(longint v, int sh);
        longint m;
        m = v < 0 ? -v : v;
        m = (m + (64'sd1 << (sh - 1))) >>> sh;
        return v < 0 ? -m : m;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // advance the predictor by one word and return the expected result
    function automatic body_word_t rebase_pose(pose_word_t p);
        body_word_t r;
        longint pos[3], q[4], rel[3], acc, w, a, b, c;
        longint mt[3][3];
        logic [127:0] sq_dist, bestd, r2;
        logic [127:0] d;
        longint dd;
        int best;
        r = '0;
        pos[0] = p.px; pos[1] = p.py; pos[2] = p.pz;
        q[0] = p.qw; q[1] = p.qx; q[2] = p.qy; q[3] = p.qz;
        if (p.cmd == CMD_PICK) begin
            best = 0;
            bestd = '0;
            for (int i = 0; i < NFRAMES; i++) begin
                sq_dist = '0;
                for (int j = 0; j < 3; j++) begin
                    dd = pos[j] - frame_val(i, j);
                    d = dd < 0 ? 128'(-dd) : 128'(dd);
                    sq_dist += d * d;
                end
                if (i == 0 || sq_dist < bestd) begin
                    bestd = sq_dist;
                    best = i;
                end
            end
            r2 = 128'(pr_radius) * 128'(pr_radius);
            pr_frame = best[3:0];
            pr_have = bestd <= r2;
        end else if (!pr_have) begin
            r.px = p.px; r.py = p.py; r.pz = p.pz;
            r.qw = p.qw; r.qx = p.qx; r.qy = p.qy; r.qz = p.qz;
        end else begin
            w = frame_val(pr_frame, 3);
            a = -frame_val(pr_frame, 4);
            b = -frame_val(pr_frame, 5);
            c = -frame_val(pr_frame, 6);
            for (int i = 0; i < 3; i++)
                rel[i] = pos[i] - frame_val(pr_frame, i);
            mt[0][0] = ONE_Q28 - 2 * (b * b + c * c);
            mt[0][1] = 2 * (a * b - w * c);
            mt[0][2] = 2 * (a * c + w * b);
            mt[1][0] = 2 * (a * b + w * c);
            mt[1][1] = ONE_Q28 - 2 * (a * a + c * c);
            mt[1][2] = 2 * (b * c - w * a);
            mt[2][0] = 2 * (a * c - w * b);
            mt[2][1] = 2 * (b * c + w * a);
            mt[2][2] = ONE_Q28 - 2 * (a * a + b * b);
            for (int i = 0; i < 3; i++) begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += mt[i][j] * rel[j];
                pos[i] = clip(rnd_shift(acc, 28), -64'sd2147483648, 64'sd2147483647);
            end
            r.px = 32'(pos[0]); r.py = 32'(pos[1]); r.pz = 32'(pos[2]);
            r.qw = 16'(clip(rnd_shift(w * q[0] - a * q[1] - b * q[2] - c * q[3], 14),
                            -32768, 32767));
            r.qx = 16'(clip(rnd_shift(w * q[1] + a * q[0] + b * q[3] - c * q[2], 14),
                            -32768, 32767));
            r.qy = 16'(clip(rnd_shift(w * q[2] - a * q[3] + b * q[0] + c * q[1], 14),
                            -32768, 32767));
            r.qz = 16'(clip(rnd_shift(w * q[3] + a * q[2] - b * q[1] + c * q[0], 14),
                            -32768, 32767));
        end
        r.ovalid = pr_have;
        r.oframe = pr_frame;
        return r;
    endfunction

    // handshake state sampled at the rising edge
    logic in_stall_s;

    // driver: present queued words with random gaps
    int gap_left = 0;
    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_stall_s) begin
            // word taken at the last rising edge
            if (gap_left == 0 && pose_q.size() != 0) begin
                drv <= pose_q.pop_front();
                gap_left = idle_rand ? $urandom_range(0, 4) : 0;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end else if (!in_valid) begin
            if (gap_left > 0)
                gap_left--;
            else if (pose_q.size() != 0) begin
                drv <= pose_q.pop_front();
                in_valid <= 1'b1;
                gap_left = idle_rand ? $urandom_range(0, 4) : 0;
            end
        end
    end

    // monitor
    int stall_left = 0;
    body_word_t want;
    always @(posedge clk)
    begin
        in_stall_s <= in_stall;
        if (rst_n && in_valid && !in_stall)
            body_q = {body_q, rebase_pose(drv)};
        if (rst_n && out_valid && !out_stall) begin
            if (body_q.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors++;
            end else begin
                want = body_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (!idle_rand)
            out_stall <= 1'b0;
        else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (out_valid && !out_stall) begin
            stall_left = $urandom_range(0, 4);
            out_stall <= stall_left != 0;
        end else
            out_stall <= 1'b0;
    end

    task automatic write_radius(logic [30:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_RADIUS; pwdata <= {1'b0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        pr_radius = val;
    endtask

    task automatic drain_all();
        while (pose_q.size() != 0 || in_valid || body_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic pose_word_t rand_pose(bit near_frame);
        pose_word_t p;
        int f;
        p.cmd = 1'($urandom_range(0, 1));
        p.px = $urandom; p.py = $urandom; p.pz = $urandom;
        p.qw = 16'($urandom); p.qx = 16'($urandom);
        p.qy = 16'($urandom); p.qz = 16'($urandom);
        if (near_frame) begin
            f = $urandom_range(0, NFRAMES - 1);
            p.px = 32'(frame_val(f, 0) + $signed($urandom_range(0, 800000)) - 400000);
            p.py = 32'(frame_val(f, 1) + $signed($urandom_range(0, 800000)) - 400000);
            p.pz = 32'(frame_val(f, 2) + $signed($urandom_range(0, 800000)) - 400000);
        end
        return p;
    endfunction

    task automatic push_pose(logic cmd, longint x, longint y, longint z,
                             longint w, longint qx, longint qy, longint qz);
        pose_word_t p;
        p.cmd = cmd; p.px = 32'(x); p.py = 32'(y); p.pz = 32'(z);
        p.qw = 16'(w); p.qx = 16'(qx); p.qy = 16'(qy); p.qz = 16'(qz);
        pose_q = {pose_q, p};
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        drv = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = ADDR_RADIUS; pwdata = '0;
        pr_have = 1'b0; pr_frame = '0; pr_radius = 31'd327680;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: pass-through, each frame exactly, extremes, far pick
        push_pose(CMD_XFORM, 32'h7fffffff, 32'h80000000, 5, 16'h7fff, 16'h8000, 1, -1);
        for (int f = 0; f < NFRAMES; f++) begin
            push_pose(CMD_PICK, frame_val(f, 0), frame_val(f, 1), frame_val(f, 2), 0, 0, 0, 0);
            push_pose(CMD_XFORM, frame_val(f, 0) + 65536, frame_val(f, 1), 32'h7fffffff,
                      16384, 0, 0, 0);
        end
        push_pose(CMD_XFORM, 32'h80000000, 32'h80000000, 32'h7fffffff,
                  16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        push_pose(CMD_PICK, 32'h80000000, 32'h80000000, 32'h80000000, -1, -1, -1, -1);
        push_pose(CMD_XFORM, -1, -1, -1, -1, -1, -1, -1);
        // x midway between frames 0 and 6, y and z zero: frame 0 is the nearest
        push_pose(CMD_PICK, (frame_val(0, 0) + frame_val(6, 0)) / 2, 0, 0, 0, 0, 0, 0);
        drain_all();

        // radius extremes, then random mixes at several settings
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_radius(31'd0);
                1: write_radius(31'h7fffffff);
                2: write_radius(31'd65536);
                3: write_radius(31'd327680);
                default: write_radius(31'($urandom));
            endcase
            if (ph == 0)
                push_pose(CMD_PICK, frame_val(3, 0), frame_val(3, 1), frame_val(3, 2),
                          0, 0, 0, 0);
            for (int k = 0; k < 260; k++)
                pose_q = {pose_q, rand_pose($urandom_range(0, 3) != 0)};
            // a stretch without idling and a full drain before the next setting
            if (ph == 2)
                idle_rand = 0;
            drain_all();
            idle_rand = 1;
        end

        drain_all();
        if (errors == 0)
            $display("nearest_origin_pose_rebase_tb: clean");
        else
            $display("nearest_origin_pose_rebase_tb: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("nearest_origin_pose_rebase_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
